>>> src/dpd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the depth pair distance pipeline.
// No dependencies; imported by every module of the block but dpd_isqrt.
package dpd_pkg;

    localparam int unsigned COORD_WIDTH_DEF = 12;
    localparam int unsigned DEPTH_WIDTH_DEF = 16;
    localparam int unsigned RPP_WIDTH       = 20;
    localparam int unsigned DIST_WIDTH      = 17;
    localparam int unsigned CFG_IDX_WIDTH   = 2;
    localparam int unsigned THETA_BASE      = 32;
    localparam int unsigned ANG_WIDTH       = 27;
    localparam int unsigned HALF_WIDTH      = 31;
    localparam int unsigned Q_WIDTH         = 33;
    localparam int unsigned SIN_STEPS       = 8;
    localparam int unsigned DIV_WIDTH       = 9;
    localparam int unsigned REC_WIDTH       = 30;

    localparam logic [RPP_WIDTH-1:0]     RPP_X_RESET = 20'd21733;
    localparam logic [RPP_WIDTH-1:0]     RPP_Y_RESET = 20'd21734;
    localparam logic [DIST_WIDTH-1:0]    DIST_MAX    = 17'd131071;
    localparam logic [ANG_WIDTH-1:0]     PI_Q24      = 27'd52707179;
    localparam logic [ANG_WIDTH-1:0]     TWO_PI_Q24  = 27'd105414358;
    localparam logic [HALF_WIDTH-1:0]    ONE_Q30     = 31'd1073741824;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_X_RPP = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_Y_RPP = 2'd1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_DEPTH = 1'b1;

    localparam logic [DIV_WIDTH-1:0] SIN_DIV [SIN_STEPS] = '{
        9'd272, 9'd210, 9'd156, 9'd110, 9'd72, 9'd42, 9'd20, 9'd6
    };

    localparam logic [REC_WIDTH-1:0] SIN_REC [SIN_STEPS] = '{
        30'(64'd4294967296 / 64'd272), 30'(64'd4294967296 / 64'd210),
        30'(64'd4294967296 / 64'd156), 30'(64'd4294967296 / 64'd110),
        30'(64'd4294967296 / 64'd72),  30'(64'd4294967296 / 64'd42),
        30'(64'd4294967296 / 64'd20),  30'(64'd4294967296 / 64'd6)
    };

    function automatic int unsigned ang_shift_max(int unsigned cw);
        int unsigned mw;
        mw = cw + RPP_WIDTH;
        return (mw > 31) ? (mw - 31) : 0;
    endfunction

endpackage

>>> src/depth_pair_distance_unit.sv
`timescale 1ns / 1ps
// Top level of the depth pair distance pipeline and its scale registers.
// Depends on dpd_pkg, dpd_angle, dpd_sin and dpd_dist.
//
//   channel  | direction | handshake             | payload
//   input    | in        | i_valid / o_stall     | point a/b x/y, depth a/b, depth ok
//   output   | out       | o_valid / i_stall     | distance_mm, status
//   config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request per cycle while i_stall does not hold the pipeline; most stages lie in the two
// square root units (32 stages and DEPTH_WIDTH + 7 stages) and the 24 stages of the sine series.
// The whole pipeline holds while a result waits under i_stall.
// Reset clears all valid bits and restores both scale registers.
module depth_pair_distance_unit
    import dpd_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int unsigned DEPTH_WIDTH = DEPTH_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [COORD_WIDTH-1:0]   i_point_a_x,
    input  logic [COORD_WIDTH-1:0]   i_point_a_y,
    input  logic [COORD_WIDTH-1:0]   i_point_b_x,
    input  logic [COORD_WIDTH-1:0]   i_point_b_y,
    input  logic [DEPTH_WIDTH-1:0]   i_depth_a_mm,
    input  logic [DEPTH_WIDTH-1:0]   i_depth_b_mm,
    input  logic                     i_depth_a_ok,
    input  logic                     i_depth_b_ok,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [DIST_WIDTH-1:0]    o_distance_mm,
    output logic                     o_status,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [RPP_WIDTH-1:0]     i_cfg_data
);

    localparam int unsigned TW = THETA_BASE + ang_shift_max(COORD_WIDTH);
    localparam int unsigned SW = 2 * DEPTH_WIDTH + 1;

    logic                 en;
    logic [RPP_WIDTH-1:0] r_rpp_x, r_rpp_y;

    logic                 ang_vld;
    logic [TW-1:0]        ang_theta;
    logic [SW-1:0]        ang_side;
    logic                 sin_vld;
    logic [Q_WIDTH-1:0]   sin_q;
    logic [SW-1:0]        sin_side;

    assign en          = !(o_valid && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpp_x <= RPP_X_RESET;
            r_rpp_y <= RPP_Y_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_X_RPP: r_rpp_x <= i_cfg_data;
                CFG_Y_RPP: r_rpp_y <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dpd_angle #(
        .CW (COORD_WIDTH),
        .SW (SW)
    ) u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_ax    (i_point_a_x),
        .i_ay    (i_point_a_y),
        .i_bx    (i_point_b_x),
        .i_by    (i_point_b_y),
        .i_rpp_x (r_rpp_x),
        .i_rpp_y (r_rpp_y),
        .i_side  ({!(i_depth_a_ok && i_depth_b_ok), i_depth_a_mm, i_depth_b_mm}),
        .o_valid (ang_vld),
        .o_theta (ang_theta),
        .o_side  (ang_side)
    );

    dpd_sin #(
        .TW (TW),
        .SW (SW)
    ) u_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ang_vld),
        .i_theta (ang_theta),
        .i_side  (ang_side),
        .o_valid (sin_vld),
        .o_q     (sin_q),
        .o_side  (sin_side)
    );

    dpd_dist #(
        .DW (DEPTH_WIDTH)
    ) u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (sin_vld),
        .i_q        (sin_q),
        .i_da       (sin_side[2*DEPTH_WIDTH-1:DEPTH_WIDTH]),
        .i_db       (sin_side[DEPTH_WIDTH-1:0]),
        .i_bad      (sin_side[SW-1]),
        .o_valid    (o_valid),
        .o_distance (o_distance_mm),
        .o_status   (o_status)
    );

endmodule

>>> src/dpd_isqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per register stage.
// Standalone; instanced by dpd_angle and dpd_dist.
module dpd_isqrt #(
    parameter int unsigned IN_WIDTH   = 64,
    parameter int unsigned SIDE_WIDTH = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [IN_WIDTH-1:0]     i_value,
    input  logic [SIDE_WIDTH-1:0]   i_side,
    output logic                    o_valid,
    output logic [IN_WIDTH/2-1:0]   o_root,
    output logic [SIDE_WIDTH-1:0]   o_side
);

    localparam int unsigned STEPS = IN_WIDTH / 2;

    logic [IN_WIDTH-1:0]   r_v   [STEPS];
    logic [IN_WIDTH-1:0]   r_r   [STEPS];
    logic [IN_WIDTH-1:0]   n_v   [STEPS];
    logic [IN_WIDTH-1:0]   n_r   [STEPS];
    logic [IN_WIDTH-1:0]   stg_v [STEPS];
    logic [IN_WIDTH-1:0]   stg_r [STEPS];
    logic [STEPS-1:0]      r_vld;
    logic [SIDE_WIDTH-1:0] r_side [STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        localparam logic [IN_WIDTH-1:0] BIT = IN_WIDTH'(1) << (IN_WIDTH - 2 - 2 * g);
        logic [IN_WIDTH-1:0] trial;

        if (g == 0) begin : g_first
            assign stg_v[g] = i_value;
            assign stg_r[g] = '0;
        end else begin : g_next
            assign stg_v[g] = r_v[g-1];
            assign stg_r[g] = r_r[g-1];
        end

        always_comb begin
            trial = stg_r[g] + BIT;
            if (stg_v[g] >= trial) begin
                n_v[g] = stg_v[g] - trial;
                n_r[g] = (stg_r[g] >> 1) + BIT;
            end else begin
                n_v[g] = stg_v[g];
                n_r[g] = stg_r[g] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[g] <= n_v[g];
                r_r[g] <= n_r[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < STEPS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[STEPS-1];
    assign o_root  = r_r[STEPS-1][IN_WIDTH/2-1:0];
    assign o_side  = r_side[STEPS-1];

endmodule

>>> src/dpd_angle.sv
`timescale 1ns / 1ps
// View angle between the two pixels: scaled offsets, sum of squares, root.
// Depends on dpd_pkg and dpd_isqrt.
module dpd_angle
    import dpd_pkg::*;
#(
    parameter int unsigned CW = COORD_WIDTH_DEF,
    parameter int unsigned SW = 1,
    localparam int unsigned TW = THETA_BASE + ang_shift_max(CW)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [CW-1:0]        i_ax,
    input  logic [CW-1:0]        i_ay,
    input  logic [CW-1:0]        i_bx,
    input  logic [CW-1:0]        i_by,
    input  logic [RPP_WIDTH-1:0] i_rpp_x,
    input  logic [RPP_WIDTH-1:0] i_rpp_y,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic [TW-1:0]        o_theta,
    output logic [SW-1:0]        o_side
);

    localparam int unsigned MW   = CW + RPP_WIDTH;
    localparam int unsigned SMAX = ang_shift_max(CW);
    localparam int unsigned SHW  = (SMAX == 0) ? 1 : $clog2(SMAX + 1);

    logic [CW-1:0]     dx, dy;
    logic [MW-1:0]     r1_mx, r1_my;
    logic              r1_vld;
    logic [SW-1:0]     r1_side;

    logic [MW-1:0]     orv;
    logic [SHW-1:0]    n_s;
    logic [30:0]       xs, ys;
    logic [61:0]       r2_sqx, r2_sqy;
    logic [SHW-1:0]    r2_s;
    logic              r2_vld;
    logic [SW-1:0]     r2_side;

    logic [63:0]       r3_sum;
    logic [SHW-1:0]    r3_s;
    logic              r3_vld;
    logic [SW-1:0]     r3_side;

    logic              sq_vld;
    logic [31:0]       sq_root;
    logic [SHW+SW-1:0] sq_side;

    logic [TW-1:0]     r4_theta;
    logic              r4_vld;
    logic [SW-1:0]     r4_side;

    always_comb begin
        dx = (i_ax >= i_bx) ? (i_ax - i_bx) : (i_bx - i_ax);
        dy = (i_ay >= i_by) ? (i_ay - i_by) : (i_by - i_ay);
    end

    always_comb begin
        orv = r1_mx | r1_my;
        n_s = '0;
        for (int k = 1; k <= SMAX; k++) begin
            if (orv[30+k]) begin
                n_s = SHW'(k);
            end
        end
        xs = 31'(r1_mx >> n_s);
        ys = 31'(r1_my >> n_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mx    <= MW'(dx) * MW'(i_rpp_x);
            r1_my    <= MW'(dy) * MW'(i_rpp_y);
            r1_side  <= i_side;
            r2_sqx   <= {31'd0, xs} * {31'd0, xs};
            r2_sqy   <= {31'd0, ys} * {31'd0, ys};
            r2_s     <= n_s;
            r2_side  <= r1_side;
            r3_sum   <= {2'b00, r2_sqx} + {2'b00, r2_sqy};
            r3_s     <= r2_s;
            r3_side  <= r2_side;
            r4_theta <= TW'(sq_root) << sq_side[SHW+SW-1:SW];
            r4_side  <= sq_side[SW-1:0];
        end
    end

    dpd_isqrt #(
        .IN_WIDTH   (64),
        .SIDE_WIDTH (SHW + SW)
    ) u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r3_vld),
        .i_value (r3_sum),
        .i_side  ({r3_s, r3_side}),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign o_valid = r4_vld;
    assign o_theta = r4_theta;
    assign o_side  = r4_side;

endmodule

>>> src/dpd_sin.sv
`timescale 1ns / 1ps
// Angle reduction and half-angle sine series, giving 1 - cos in Q.30.
// Depends on dpd_pkg.
module dpd_sin
    import dpd_pkg::*;
#(
    parameter int unsigned TW = THETA_BASE,
    parameter int unsigned SW = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [TW-1:0]      i_theta,
    input  logic [SW-1:0]      i_side,
    output logic               o_valid,
    output logic [Q_WIDTH-1:0] o_q,
    output logic [SW-1:0]      o_side
);

    localparam int unsigned MSTEPS = TW - ANG_WIDTH + 1;
    localparam int unsigned PS     = 3 * SIN_STEPS;
    localparam int unsigned NS     = MSTEPS + 2 + PS + 2;

    logic [NS-1:0]         r_vld;
    logic [SW-1:0]         r_side [NS];

    logic [TW-1:0]         r_m [MSTEPS];
    logic [TW-1:0]         n_m [MSTEPS];
    logic [ANG_WIDTH-1:0]  rr, fold;
    logic [HALF_WIDTH-1:0] r_h, r_hb;
    logic [31:0]           r_h2;

    logic [HALF_WIDTH-1:0] r_ph  [PS];
    logic [31:0]           r_ph2 [PS];
    logic [31:0]           r_x   [SIN_STEPS];
    logic [61:0]           r_prod[SIN_STEPS];
    logic [31:0]           r_x2  [SIN_STEPS];
    logic [HALF_WIDTH-1:0] r_t   [SIN_STEPS];

    logic [HALF_WIDTH-1:0] r_sn;
    logic [Q_WIDTH-1:0]    r_q;

    for (genvar g = 0; g < MSTEPS; g++) begin : g_mod
        localparam logic [TW-1:0] SUB = TW'(TWO_PI_Q24) << (MSTEPS - 1 - g);
        logic [TW-1:0] vin;
        if (g == 0) begin : g_first
            assign vin = i_theta;
        end else begin : g_next
            assign vin = r_m[g-1];
        end
        assign n_m[g] = (vin >= SUB) ? (vin - SUB) : vin;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[g] <= n_m[g];
            end
        end
    end

    always_comb begin
        rr   = r_m[MSTEPS-1][ANG_WIDTH-1:0];
        fold = (rr > PI_Q24) ? (TWO_PI_Q24 - rr) : rr;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h  <= {fold[25:0], 5'b00000};
            r_h2 <= 32'(({31'd0, r_h} * {31'd0, r_h}) >> 30);
            r_hb <= r_h;
        end
    end

    for (genvar j = 0; j < PS; j++) begin : g_carry
        if (j == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ph[j]  <= r_hb;
                    r_ph2[j] <= r_h2;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ph[j]  <= r_ph[j-1];
                    r_ph2[j] <= r_ph2[j-1];
                end
            end
        end
    end

    for (genvar i = 0; i < SIN_STEPS; i++) begin : g_series
        logic [HALF_WIDTH-1:0] t_in;
        logic [31:0]           h2_in;
        logic [31:0]           qe, qc, rem;

        if (i == 0) begin : g_first
            assign t_in  = ONE_Q30;
            assign h2_in = r_h2;
        end else begin : g_next
            assign t_in  = r_t[i-1];
            assign h2_in = r_ph2[3*i-1];
        end

        always_comb begin
            qe  = 32'(r_prod[i] >> 32);
            rem = r_x2[i] - 32'({9'd0, qe} * {32'd0, SIN_DIV[i]});
            qc  = (rem >= 32'(SIN_DIV[i])) ? (qe + 32'd1) : qe;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i]    <= 32'(({31'd0, h2_in} * {32'd0, t_in}) >> 30);
                r_prod[i] <= {30'd0, r_x[i]} * {32'd0, SIN_REC[i]};
                r_x2[i]   <= r_x[i];
                r_t[i]    <= ONE_Q30 - qc[HALF_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sn <= HALF_WIDTH'(({31'd0, r_ph[PS-1]} * {31'd0, r_t[SIN_STEPS-1]}) >> 30);
            r_q  <= Q_WIDTH'(({31'd0, r_sn} * {31'd0, r_sn}) >> 29);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < NS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_q     = r_q;
    assign o_side  = r_side[NS-1];

endmodule

>>> src/dpd_dist.sv
`timescale 1ns / 1ps
// Law of cosines on the two depths, square root, rounding and saturation.
// Depends on dpd_pkg and dpd_isqrt; holds the output register.
module dpd_dist
    import dpd_pkg::*;
#(
    parameter int unsigned DW = DEPTH_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [Q_WIDTH-1:0]    i_q,
    input  logic [DW-1:0]         i_da,
    input  logic [DW-1:0]         i_db,
    input  logic                  i_bad,
    output logic                  o_valid,
    output logic [DIST_WIDTH-1:0] o_distance,
    output logic                  o_status
);

    localparam int unsigned PW  = 2 * DW + Q_WIDTH;
    localparam int unsigned D2W = 2 * DW + 14;
    localparam int unsigned RTW = D2W / 2;
    localparam int unsigned RW  = RTW - 3;
    localparam int unsigned EW  = RW + DIST_WIDTH;

    logic [DW-1:0]          diff;
    logic [2*DW-1:0]        r1_ab, r1_dsq;
    logic [Q_WIDTH-1:0]     r1_q;
    logic                   r1_bad, r1_vld;

    logic [DW+Q_WIDTH-1:0]  r2_plo, r2_phi;
    logic [2*DW-1:0]        r2_dsq;
    logic                   r2_bad, r2_vld;

    logic [PW-1:0]          r3_p;
    logic [2*DW-1:0]        r3_dsq;
    logic                   r3_bad, r3_vld;

    logic [D2W-1:0]         r4_d2;
    logic                   r4_bad, r4_vld;

    logic                   sq_vld, sq_bad;
    logic [RTW-1:0]         sq_root;

    logic [RTW:0]           rsum;
    logic [RW-1:0]          rnd;
    logic [DIST_WIDTH-1:0]  n_dist;
    logic                   n_status;

    logic [DIST_WIDTH-1:0]  r_dist;
    logic                   r_status, r_vld;

    assign diff = (i_da >= i_db) ? (i_da - i_db) : (i_db - i_da);

    always_comb begin
        rsum = {1'b0, sq_root} + (RTW+1)'(8);
        rnd  = rsum[RTW:4];
        if (sq_bad) begin
            n_dist   = '0;
            n_status = STATUS_BAD_DEPTH;
        end else begin
            n_dist   = (EW'(rnd) > EW'(DIST_MAX)) ? DIST_MAX : DIST_WIDTH'(rnd);
            n_status = STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r_vld  <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r_vld  <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ab    <= (2*DW)'(i_da) * (2*DW)'(i_db);
            r1_dsq   <= (2*DW)'(diff) * (2*DW)'(diff);
            r1_q     <= i_q;
            r1_bad   <= i_bad;
            r2_plo   <= (DW+Q_WIDTH)'(r1_ab[DW-1:0]) * (DW+Q_WIDTH)'(r1_q);
            r2_phi   <= (DW+Q_WIDTH)'(r1_ab[2*DW-1:DW]) * (DW+Q_WIDTH)'(r1_q);
            r2_dsq   <= r1_dsq;
            r2_bad   <= r1_bad;
            r3_p     <= (PW'(r2_phi) << DW) + PW'(r2_plo);
            r3_dsq   <= r2_dsq;
            r3_bad   <= r2_bad;
            r4_d2    <= (D2W'(r3_dsq) << 8) + D2W'(r3_p >> 21);
            r4_bad   <= r3_bad;
            r_dist   <= n_dist;
            r_status <= n_status;
        end
    end

    dpd_isqrt #(
        .IN_WIDTH   (D2W),
        .SIDE_WIDTH (1)
    ) u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r4_vld),
        .i_value (r4_d2),
        .i_side  (r4_bad),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_bad)
    );

    assign o_valid    = r_vld;
    assign o_distance = r_dist;
    assign o_status   = r_status;

endmodule

>>> tb/dpd_checker.sv
`timescale 1ns / 1ps
// Distance checker for the depth pair distance pipeline: predicts every
// accepted request and compares results in order. Depends on dpd_pkg.
module dpd_checker
    import dpd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic                     i_in_stall,
    input  logic [11:0]              i_ax,
    input  logic [11:0]              i_ay,
    input  logic [11:0]              i_bx,
    input  logic [11:0]              i_by,
    input  logic [15:0]              i_da,
    input  logic [15:0]              i_db,
    input  logic                     i_da_ok,
    input  logic                     i_db_ok,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic [DIST_WIDTH-1:0]    i_distance_mm,
    input  logic                     i_status,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [RPP_WIDTH-1:0]     i_cfg_data,
    output int                       o_errors,
    output int                       o_pending
);

    typedef struct packed {
        logic [DIST_WIDTH-1:0] distance;
        logic                  status;
    } t_dist_result;

    t_dist_result    expected_q[$];
    logic [RPP_WIDTH-1:0] x_scale, y_scale;

    assign o_pending = expected_q.size();

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_dist_result predict_distance(
        input logic [11:0] ax, ay, bx, by,
        input logic [15:0] da, db,
        input logic aok, bok
    );
        t_dist_result res;
        logic [63:0] mx, my, theta, r, h, h2, t, sn, q, dd, d2, dist_v;
        logic [127:0] wide;
        int s;
        int unsigned divs [8] = '{272, 210, 156, 110, 72, 42, 20, 6};
        if (!aok || !bok) begin
            res.distance = '0;
            res.status = STATUS_BAD_DEPTH;
            return res;
        end
        mx = 64'(ax > bx ? ax - bx : bx - ax) * x_scale;
        my = 64'(ay > by ? ay - by : by - ay) * y_scale;
        s = 0;
        while (((mx >> s) | (my >> s)) >= (64'd1 << 31)) s++;
        theta = root64((mx >> s) * (mx >> s) + (my >> s) * (my >> s)) << s;
        r = theta % 64'd105414358;
        if (r > 64'd52707179) r = 64'd105414358 - r;
        h = r << 5;
        h2 = (h * h) >> 30;
        t = 64'd1 << 30;
        for (int k = 0; k < 8; k++)
            t = (64'd1 << 30) - ((h2 * t) >> 30) / divs[k];
        sn = (h * t) >> 30;
        q = (sn * sn) >> 29;
        dd = 64'(da > db ? da - db : db - da);
        d2 = (dd * dd) << 8;
        wide = (128'(2) * da * db * q) >> 22;
        d2 = d2 + wide[63:0];
        dist_v = (root64(d2) + 8) >> 4;
        if (dist_v > 131071) dist_v = 131071;
        res.distance = dist_v[DIST_WIDTH-1:0];
        res.status = STATUS_OK;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_dist_result exp_r;
        if (!i_rst_n) begin
            x_scale <= RPP_X_RESET;
            y_scale <= RPP_Y_RESET;
        end else begin
            if (i_valid && !i_in_stall)
                expected_q.push_back(predict_distance(i_ax, i_ay, i_bx, i_by,
                    i_da, i_db, i_da_ok, i_db_ok));
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with no request pending");
                end else begin
                    exp_r = expected_q.pop_front();
                    if (i_distance_mm !== exp_r.distance)
                        report_mismatch($sformatf("distance %0d, expected %0d",
                            i_distance_mm, exp_r.distance));
                    if (i_status !== exp_r.status)
                        report_mismatch($sformatf("status %0b, expected %0b",
                            i_status, exp_r.status));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_X_RPP) x_scale <= i_cfg_data;
                else if (i_cfg_index == CFG_Y_RPP) y_scale <= i_cfg_data;
            end
        end
    end

endmodule

>>> tb/tb_depth_pair_distance_unit.sv
`timescale 1ns / 1ps
// Stimulus and verdict for depth_pair_distance_unit across several scale
// settings. Depends on dpd_pkg, the block and dpd_checker.
module tb_depth_pair_distance_unit;
    import dpd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNUSED = 2'd3;

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall;
    logic [11:0] ax, ay, bx, by;
    logic [15:0] da, db;
    logic aok, bok, o_status, cfg_valid, o_cfg_ready;
    logic [DIST_WIDTH-1:0] o_distance_mm;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [RPP_WIDTH-1:0] cfg_data;
    int errors, pending, cycles;
    bit calm, hold_off;

    depth_pair_distance_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_point_a_x(ax), .i_point_a_y(ay), .i_point_b_x(bx), .i_point_b_y(by),
        .i_depth_a_mm(da), .i_depth_b_mm(db), .i_depth_a_ok(aok),
        .i_depth_b_ok(bok), .o_valid(o_valid), .i_stall(i_stall),
        .o_distance_mm(o_distance_mm), .o_status(o_status),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    dpd_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_in_stall(o_stall),
        .i_ax(ax), .i_ay(ay), .i_bx(bx), .i_by(by), .i_da(da), .i_db(db),
        .i_da_ok(aok), .i_db_ok(bok), .i_out_valid(o_valid),
        .i_out_stall(i_stall), .i_distance_mm(o_distance_mm),
        .i_status(o_status), .i_cfg_valid(cfg_valid),
        .i_cfg_ready(o_cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, one long hold-off, none when calm
    initial begin
        int n;
        i_stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_stall <= 1;
                repeat (200) @(negedge i_clk);
                i_stall <= 0;
                hold_off = 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 5);
                i_stall <= 1;
                repeat (n) @(negedge i_clk);
                i_stall <= 0;
            end
        end
    end

    task automatic send_request(input logic [11:0] pax, pay, pbx, pby,
                                input logic [15:0] pda, pdb, input logic pa, pb);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_valid <= 1;
        ax <= pax; ay <= pay; bx <= pbx; by <= pby;
        da <= pda; db <= pdb; aok <= pa; bok <= pb;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_scale(input logic [CFG_IDX_WIDTH-1:0] idx,
                               input logic [RPP_WIDTH-1:0] val);
        i_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 0;
    endtask

    task automatic send_random(input int mode);
        logic [11:0] c [4];
        for (int k = 0; k < 4; k++)
            c[k] = (mode == 0) ? 12'($urandom) : 12'($urandom_range(0, 300));
        send_request(c[0], c[1], c[2], c[3], 16'($urandom), 16'($urandom),
                     $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
    endtask

    initial begin
        logic [RPP_WIDTH-1:0] scales [4] = '{20'd21733, 20'hFFFFF, 20'd0, 20'd400000};
        calm = 0;
        hold_off = 0;
        i_valid = 0; cfg_valid = 0; cfg_index = CFG_X_RPP; cfg_data = 0;
        ax = 0; ay = 0; bx = 0; by = 0; da = 0; db = 0; aok = 1; bok = 1;
        i_rst_n = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        send_request(0, 0, 0, 0, 0, 0, 1, 1);
        send_request(0, 0, 4095, 4095, 65535, 65535, 1, 1);
        send_request(4095, 4095, 0, 0, 65535, 0, 1, 1);
        send_request(0, 0, 4095, 0, 1000, 2000, 1, 1);
        send_request(0, 0, 0, 4095, 2000, 1000, 1, 1);
        send_request(640, 360, 1280, 720, 0, 3000, 1, 1);
        send_request(10, 20, 30, 40, 5000, 5000, 0, 1);
        send_request(10, 20, 30, 40, 5000, 5000, 1, 0);
        send_request(10, 20, 30, 40, 5000, 5000, 0, 0);
        send_request(12'hAAA, 12'h555, 12'h555, 12'hAAA, 16'hAAAA, 16'h5555, 1, 1);
        send_request(12'h555, 12'hAAA, 12'hAAA, 12'h555, 16'h5555, 16'hAAAA, 1, 1);

        for (int p = 0; p < 4; p++) begin
            write_scale(CFG_X_RPP, scales[p]);
            write_scale(CFG_Y_RPP, scales[3 - p]);
            if (p == 1) write_scale(CFG_UNUSED, 20'd12345);
            if (p == 3) calm = 1;
            for (int i = 0; i < 340; i++) begin
                if (p == 1 && i == 50) hold_off = 1;
                send_random($urandom_range(0, 1));
            end
        end

        i_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
